>>> design/sgr_pkg.sv
package sgr_pkg;

   localparam int MaxValues  = 3;
   localparam int CountWidth = $clog2(MaxValues + 1);
   localparam int IdxWidth   = (MaxValues > 1) ? $clog2(MaxValues) : 1;
   localparam int MaxResults = 3;
   localparam int FifoDepth  = 4;
   localparam int PtrWidth   = $clog2(FifoDepth);
   localparam int FillWidth  = $clog2(FifoDepth + 1);

   localparam logic [7:0] ChEsc  = 8'h1B;
   localparam logic [7:0] ChOpen = 8'h5B;
   localparam logic [7:0] ChM    = 8'h6D;
   localparam logic [7:0] ChSemi = 8'h3B;
   localparam logic [7:0] ChNul  = 8'h00;

   localparam logic [7:0] CodeReset  = 8'd0;
   localparam logic [7:0] CodeBright = 8'd1;
   localparam logic [7:0] CodeFgLow  = 8'd30;
   localparam logic [7:0] CodeFgHigh = 8'd37;

   localparam logic [23:0] White = 24'hFFFFFF;

   localparam logic OpText  = 1'b0;
   localparam logic OpClear = 1'b1;

   localparam logic KindChar  = 1'b0;
   localparam logic KindBreak = 1'b1;

   typedef enum logic [2:0] {
      ModeText = 3'b001,
      ModeEsc  = 3'b010,
      ModeSeq  = 3'b100
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] char_out;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_last;
   } result_type;

   function automatic logic [23:0] palette(input logic [3:0] idx);
      logic [23:0] rgb;
      case (idx)
         4'd0:    rgb = 24'h000000;
         4'd1:    rgb = 24'hFF0000;
         4'd2:    rgb = 24'h00FF00;
         4'd3:    rgb = 24'hFFFF00;
         4'd4:    rgb = 24'h0000FF;
         4'd5:    rgb = 24'hFF00FF;
         4'd6:    rgb = 24'h00FFFF;
         4'd7:    rgb = 24'hDCDCDC;
         4'd8:    rgb = 24'h808080;
         4'd9:    rgb = 24'hFF4040;
         4'd10:   rgb = 24'h40FF40;
         4'd11:   rgb = 24'hFFFF40;
         4'd12:   rgb = 24'h4040FF;
         4'd13:   rgb = 24'hFF40FF;
         4'd14:   rgb = 24'h40FFFF;
         default: rgb = 24'hFFFFFF;
      endcase
      return rgb;
   endfunction

endpackage

>>> design/ansi_sgr_color_text_parser.sv
// ANSI SGR color text parser. Takes one text byte per cycle when not stalled and
// returns colored characters and segment breaks on the rsp_ channel, each
// carrying the 24-bit color in force after the byte. ESC '[' values ';' ... 'm'
// selects white (0) or one of eight palette colors (30..37), brightened by an
// earlier 1 in the same sequence. A byte is decoded in the cycle it is accepted
// and its zero to three results are written at once into a four-entry result
// buffer that drains one result per cycle while rsp_stall is low. A new byte is
// taken every cycle while the buffer holds at most one result, so a stream of
// single-result bytes runs at one byte per cycle while rsp_stall is low; a byte
// that yields two or three results (a lone ESC, a break at string end) holds off
// further bytes until the buffer drains back to one result.
module ansi_sgr_color_text_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_char_in,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_run_last
);

   sgr_pkg::mode_type                 mode_ff, mode_in;
   logic [7:0]                        acc_ff, acc_in;
   logic [7:0]                        vals_ff [sgr_pkg::MaxValues];
   logic [7:0]                        vals_in [sgr_pkg::MaxValues];
   logic [sgr_pkg::CountWidth-1:0]    cnt_ff, cnt_in;
   logic [23:0]                       colour_ff, colour_in;
   logic                              nonempty_ff, nonempty_in;

   sgr_pkg::result_type               fifo_ff [sgr_pkg::FifoDepth];
   logic [sgr_pkg::PtrWidth-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [sgr_pkg::PtrWidth-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [sgr_pkg::FillWidth-1:0]     fill_ff, fill_in;

   logic                              req_fire;
   logic                              rsp_fire;
   logic [1:0]                        n_res;
   logic                              slot_kind [sgr_pkg::MaxResults];
   logic [7:0]                        slot_char [sgr_pkg::MaxResults];
   sgr_pkg::result_type               push_entry [sgr_pkg::MaxResults];
   logic                              text_en;
   logic                              bright;
   logic [sgr_pkg::CountWidth-1:0]    eff_cnt;
   logic [7:0]                        apply_vals [sgr_pkg::MaxValues];
   logic [11:0]                       acc_wide;
   logic [7:0]                        pal_off;
   sgr_pkg::result_type               head;

   assign req_stall = (fill_ff > sgr_pkg::FillWidth'(1));
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (fill_ff != '0);
   assign rsp_fire  = rsp_valid && !rsp_stall;

   assign acc_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                   + {8'd0, req_char_in[3:0]};

   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      vals_in     = vals_ff;
      cnt_in      = cnt_ff;
      colour_in   = colour_ff;
      nonempty_in = nonempty_ff;
      n_res       = 2'd0;
      text_en     = 1'b0;
      bright      = 1'b0;
      eff_cnt     = cnt_ff;
      apply_vals  = vals_ff;
      pal_off     = 8'd0;
      for (int k = 0; k < sgr_pkg::MaxResults; k++) begin
         slot_kind[k] = sgr_pkg::KindChar;
         slot_char[k] = 8'd0;
      end

      if (req_fire) begin
         if (req_operation == sgr_pkg::OpClear) begin
            mode_in     = sgr_pkg::ModeText;
            acc_in      = 8'd0;
            cnt_in      = '0;
            colour_in   = sgr_pkg::White;
            nonempty_in = 1'b0;
            for (int k = 0; k < sgr_pkg::MaxValues; k++) begin
               vals_in[k] = 8'd0;
            end
         end else begin
            if (req_char_in != sgr_pkg::ChNul) begin
               case (mode_ff)
                  sgr_pkg::ModeEsc: begin
                     if (req_char_in == sgr_pkg::ChOpen) begin
                        if (nonempty_ff) begin
                           slot_kind[n_res] = sgr_pkg::KindBreak;
                           slot_char[n_res] = 8'd0;
                           n_res            = n_res + 2'd1;
                        end
                        nonempty_in = 1'b0;
                        acc_in      = 8'd0;
                        cnt_in      = '0;
                        mode_in     = sgr_pkg::ModeSeq;
                     end else begin
                        // stray ESC goes out as text, then the byte itself unless it is another ESC
                        slot_kind[n_res] = sgr_pkg::KindChar;
                        slot_char[n_res] = sgr_pkg::ChEsc;
                        n_res            = n_res + 2'd1;
                        nonempty_in      = 1'b1;
                        text_en          = 1'b1;
                     end
                  end
                  sgr_pkg::ModeSeq: begin
                     if (req_char_in == sgr_pkg::ChM) begin
                        if (cnt_ff < sgr_pkg::CountWidth'(sgr_pkg::MaxValues)) begin
                           apply_vals[cnt_ff[sgr_pkg::IdxWidth-1:0]] = acc_ff;
                           vals_in[cnt_ff[sgr_pkg::IdxWidth-1:0]]    = acc_ff;
                           eff_cnt = cnt_ff + sgr_pkg::CountWidth'(1);
                        end else begin
                           eff_cnt = sgr_pkg::CountWidth'(sgr_pkg::MaxValues);
                        end
                        for (int i = 0; i < sgr_pkg::MaxValues; i++) begin
                           if (sgr_pkg::CountWidth'(i) < eff_cnt) begin
                              if (apply_vals[i] == sgr_pkg::CodeReset) begin
                                 colour_in = sgr_pkg::White;
                              end else if (apply_vals[i] == sgr_pkg::CodeBright) begin
                                 bright = 1'b1;
                              end else if (apply_vals[i] >= sgr_pkg::CodeFgLow &&
                                           apply_vals[i] <= sgr_pkg::CodeFgHigh) begin
                                 pal_off   = apply_vals[i] - sgr_pkg::CodeFgLow;
                                 colour_in = sgr_pkg::palette({bright, pal_off[2:0]});
                              end
                           end
                        end
                        mode_in = sgr_pkg::ModeText;
                        acc_in  = 8'd0;
                        cnt_in  = '0;
                     end else if (cnt_ff >= sgr_pkg::CountWidth'(sgr_pkg::MaxValues)) begin
                        acc_in  = 8'd0;
                        cnt_in  = '0;
                        text_en = 1'b1;
                     end else if (req_char_in inside {["0":"9"]}) begin
                        acc_in = (acc_wide > 12'd255) ? 8'd255 : acc_wide[7:0];
                     end else if (req_char_in == sgr_pkg::ChSemi) begin
                        vals_in[cnt_ff[sgr_pkg::IdxWidth-1:0]] = acc_ff;
                        cnt_in = cnt_ff + sgr_pkg::CountWidth'(1);
                        acc_in = 8'd0;
                     end else begin
                        // abandon the sequence, byte falls back to text
                        acc_in  = 8'd0;
                        cnt_in  = '0;
                        text_en = 1'b1;
                     end
                  end
                  default: begin
                     text_en = 1'b1;
                  end
               endcase

               if (text_en) begin
                  if (req_char_in == sgr_pkg::ChEsc) begin
                     mode_in = sgr_pkg::ModeEsc;
                  end else begin
                     mode_in          = sgr_pkg::ModeText;
                     slot_kind[n_res] = sgr_pkg::KindChar;
                     slot_char[n_res] = req_char_in;
                     n_res            = n_res + 2'd1;
                     nonempty_in      = 1'b1;
                  end
               end
            end

            if (req_string_end) begin
               if (mode_in == sgr_pkg::ModeEsc) begin
                  slot_kind[n_res] = sgr_pkg::KindChar;
                  slot_char[n_res] = sgr_pkg::ChEsc;
                  n_res            = n_res + 2'd1;
                  nonempty_in      = 1'b1;
               end
               if (nonempty_in) begin
                  slot_kind[n_res] = sgr_pkg::KindBreak;
                  slot_char[n_res] = 8'd0;
                  n_res            = n_res + 2'd1;
               end
               nonempty_in = 1'b0;
               mode_in     = sgr_pkg::ModeText;
               acc_in      = 8'd0;
               cnt_in      = '0;
            end
         end
      end
   end

   // every result of a byte carries the color left after that byte
   always_comb begin
      for (int k = 0; k < sgr_pkg::MaxResults; k++) begin
         push_entry[k].kind     = slot_kind[k];
         push_entry[k].char_out = slot_char[k];
         push_entry[k].red      = colour_in[23:16];
         push_entry[k].green    = colour_in[15:8];
         push_entry[k].blue     = colour_in[7:0];
         push_entry[k].run_last = (2'(k) == n_res - 2'd1);
      end
   end

   assign wr_ptr_in = wr_ptr_ff + sgr_pkg::PtrWidth'(n_res);
   assign rd_ptr_in = rd_ptr_ff + sgr_pkg::PtrWidth'(rsp_fire);
   assign fill_in   = fill_ff + sgr_pkg::FillWidth'(n_res)
                    - sgr_pkg::FillWidth'(rsp_fire);

   always_ff @(posedge clock) begin
      for (int k = 0; k < sgr_pkg::MaxResults; k++) begin
         if (2'(k) < n_res) begin
            fifo_ff[wr_ptr_ff + sgr_pkg::PtrWidth'(k)] <= push_entry[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= sgr_pkg::ModeText;
         acc_ff      <= 8'd0;
         cnt_ff      <= '0;
         colour_ff   <= sgr_pkg::White;
         nonempty_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fill_ff     <= '0;
         for (int k = 0; k < sgr_pkg::MaxValues; k++) begin
            vals_ff[k] <= 8'd0;
         end
      end else begin
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         colour_ff   <= colour_in;
         nonempty_ff <= nonempty_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fill_ff     <= fill_in;
         vals_ff     <= vals_in;
      end
   end

   assign head         = fifo_ff[rd_ptr_ff];
   assign rsp_kind     = head.kind;
   assign rsp_char_out = head.char_out;
   assign rsp_red      = head.red;
   assign rsp_green    = head.green;
   assign rsp_blue     = head.blue;
   assign rsp_run_last = head.run_last;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= sgr_pkg::FillWidth'(sgr_pkg::FifoDepth))
      else $error("result buffer overfilled");

   a_break_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == sgr_pkg::KindBreak |-> rsp_char_out == 8'd0)
      else $error("segment break carries a character");

   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_operation == sgr_pkg::OpText && req_string_end
      |=> mode_ff == sgr_pkg::ModeText && !nonempty_ff && cnt_ff == '0)
      else $error("string end left parse state open");

   a_clear_white: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_operation == sgr_pkg::OpClear
      |=> colour_ff == sgr_pkg::White && fill_ff == $past(fill_ff)
          - sgr_pkg::FillWidth'($past(rsp_fire)))
      else $error("clear produced results or kept color");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= sgr_pkg::CountWidth'(sgr_pkg::MaxValues))
      else $error("value count past limit");

endmodule

>>> tb/sgr_color_checker.sv
module sgr_color_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic       req_operation,
   input  logic [7:0] req_char_in,
   input  logic       req_string_end,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_kind,
   input  logic [7:0] rsp_char_out,
   input  logic [7:0] rsp_red,
   input  logic [7:0] rsp_green,
   input  logic [7:0] rsp_blue,
   input  logic       rsp_run_last,
   output int         error_count,
   output int         pending_count
);

   localparam logic [7:0] ChZero = 8'h30;
   localparam logic [7:0] ChNine = 8'h39;

   sgr_pkg::mode_type    parse_state;
   logic [7:0]           num_acc;
   logic [7:0]           num_list [sgr_pkg::MaxValues];
   int                   num_count;
   logic [23:0]          pen_color;
   bit                   segment_has_text;

   sgr_pkg::result_type  colored_q [$];
   sgr_pkg::result_type  got;
   sgr_pkg::result_type  want;
   int                   fail_tally;

   function automatic logic [23:0] fg_rgb(input bit bright, input logic [2:0] hue);
      logic [7:0]  lo;
      logic [23:0] rgb;
      lo = bright ? 8'h40 : 8'h00;
      if (hue == 3'd0) begin
         rgb = bright ? 24'h808080 : 24'h000000;
      end else if (hue == 3'd7) begin
         rgb = bright ? 24'hFFFFFF : 24'hDCDCDC;
      end else begin
         rgb = {hue[0] ? 8'hFF : lo, hue[1] ? 8'hFF : lo, hue[2] ? 8'hFF : lo};
      end
      return rgb;
   endfunction

   task automatic push_result(input logic kind, input logic [7:0] ch);
      sgr_pkg::result_type r;
      r.kind     = kind;
      r.char_out = ch;
      r.red      = pen_color[23:16];
      r.green    = pen_color[15:8];
      r.blue     = pen_color[7:0];
      r.run_last = 1'b0;
      colored_q.push_back(r);
   endtask

   task automatic end_sequence();
      parse_state = sgr_pkg::ModeText;
      num_acc     = 8'd0;
      num_count   = 0;
   endtask

   task automatic reset_model();
      int i;
      end_sequence();
      for (i = 0; i < sgr_pkg::MaxValues; i++) num_list[i] = 8'd0;
      pen_color        = sgr_pkg::White;
      segment_has_text = 1'b0;
   endtask

   task automatic plain_byte(input logic [7:0] ch);
      if (ch == sgr_pkg::ChEsc) begin
         parse_state = sgr_pkg::ModeEsc;
      end else begin
         parse_state = sgr_pkg::ModeText;
         push_result(sgr_pkg::KindChar, ch);
         segment_has_text = 1'b1;
      end
   endtask

   task automatic apply_sgr();
      int used;
      int i;
      bit bright;
      if (num_count < sgr_pkg::MaxValues) begin
         num_list[num_count] = num_acc;
         used = num_count + 1;
      end else begin
         used = sgr_pkg::MaxValues;
      end
      bright = 1'b0;
      for (i = 0; i < used; i++) begin
         if (num_list[i] == sgr_pkg::CodeReset) begin
            pen_color = sgr_pkg::White;
         end else if (num_list[i] == sgr_pkg::CodeBright) begin
            bright = 1'b1;
         end else if (num_list[i] >= sgr_pkg::CodeFgLow &&
                      num_list[i] <= sgr_pkg::CodeFgHigh) begin
            pen_color = fg_rgb(bright, 3'(num_list[i] - sgr_pkg::CodeFgLow));
         end
      end
      end_sequence();
   endtask

   task automatic predict_item(input logic op, input logic [7:0] ch, input logic fin);
      int first;
      int grown;
      sgr_pkg::result_type tail;
      first = colored_q.size();
      if (op == sgr_pkg::OpClear) begin
         reset_model();
         return;
      end
      if (ch != sgr_pkg::ChNul) begin
         case (parse_state)
            sgr_pkg::ModeEsc: begin
               if (ch == sgr_pkg::ChOpen) begin
                  if (segment_has_text) push_result(sgr_pkg::KindBreak, sgr_pkg::ChNul);
                  segment_has_text = 1'b0;
                  end_sequence();
                  parse_state = sgr_pkg::ModeSeq;
               end else begin
                  push_result(sgr_pkg::KindChar, sgr_pkg::ChEsc);
                  segment_has_text = 1'b1;
                  plain_byte(ch);
               end
            end
            sgr_pkg::ModeSeq: begin
               if (ch == sgr_pkg::ChM) begin
                  apply_sgr();
               end else if (num_count >= sgr_pkg::MaxValues) begin
                  end_sequence();
                  plain_byte(ch);
               end else if (ch >= ChZero && ch <= ChNine) begin
                  grown   = int'(num_acc) * 10 + int'(ch) - int'(ChZero);
                  num_acc = (grown > 255) ? 8'd255 : 8'(grown);
               end else if (ch == sgr_pkg::ChSemi) begin
                  num_list[num_count] = num_acc;
                  num_count++;
                  num_acc = 8'd0;
               end else begin
                  end_sequence();
                  plain_byte(ch);
               end
            end
            default: plain_byte(ch);
         endcase
      end
      if (fin) begin
         if (parse_state == sgr_pkg::ModeEsc) begin
            push_result(sgr_pkg::KindChar, sgr_pkg::ChEsc);
            segment_has_text = 1'b1;
         end
         if (segment_has_text) push_result(sgr_pkg::KindBreak, sgr_pkg::ChNul);
         segment_has_text = 1'b0;
         end_sequence();
      end
      // flag the final result of this transaction
      if (colored_q.size() > first) begin
         tail = colored_q.pop_back();
         tail.run_last = 1'b1;
         colored_q.push_back(tail);
      end
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         fail_tally++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         colored_q.delete();
         fail_tally = 0;
      end else begin
         if (req_valid && !req_stall) predict_item(req_operation, req_char_in, req_string_end);
         if (rsp_valid && !rsp_stall) begin
            got.kind     = rsp_kind;
            got.char_out = rsp_char_out;
            got.red      = rsp_red;
            got.green    = rsp_green;
            got.blue     = rsp_blue;
            got.run_last = rsp_run_last;
            if (colored_q.size() == 0) begin
               $display("%0t: result with none expected: expected nothing, actual %h",
                        $time, got);
               fail_tally++;
            end else begin
               want = colored_q.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("char_out", want.char_out, got.char_out);
               check_field("red", want.red, got.red);
               check_field("green", want.green, got.green);
               check_field("blue", want.blue, got.blue);
               check_field("run_last", want.run_last, got.run_last);
            end
         end
      end
      error_count   <= fail_tally;
      pending_count <= colored_q.size();
   end

endmodule

>>> tb/tb_ansi_sgr_color_text_parser.sv
module tb_ansi_sgr_color_text_parser;

   localparam int QuietLimit = 1000;
   localparam int RandomItems = 320;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic       req_operation;
   logic [7:0] req_char_in;
   logic       req_string_end;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_kind;
   logic [7:0] rsp_char_out;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       rsp_run_last;

   int         error_count;
   int         pending_count;
   int         req_gap_pct;
   int         stall_pct;
   int         stall_left;
   int         sent;
   int         quiet_cycles;
   logic [7:0] chunk_q [$];

   ansi_sgr_color_text_parser i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_in    (req_char_in),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_char_out   (rsp_char_out),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_run_last   (rsp_run_last)
   );

   sgr_color_checker i_color_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_char_in    (req_char_in),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_char_out   (rsp_char_out),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_run_last   (rsp_run_last),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap(input int pct);
      if (pct == 0 || $urandom_range(99, 0) >= pct) return 0;
      if ($urandom_range(99, 0) < 85) return $urandom_range(3, 1);
      return $urandom_range(24, 5);
   endfunction

   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left == 0) stall_left = pick_gap(stall_pct);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("ansi_sgr_color_text_parser regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic op, input logic [7:0] ch, input logic fin);
      int gap;
      gap = pick_gap(req_gap_pct);
      repeat (gap) begin
         @(negedge clock);
         req_valid      = 1'b0;
         req_operation  = 1'($urandom_range(1, 0));
         req_char_in    = 8'($urandom_range(255, 0));
         req_string_end = 1'($urandom_range(1, 0));
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_operation  = op;
      req_char_in    = ch;
      req_string_end = fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == sgr_pkg::OpText && (ch != sgr_pkg::ChNul || fin)) sent++;
   endtask

   task automatic add_str(input string s);
      int i;
      for (i = 0; i < s.len(); i++) chunk_q.push_back(s[i]);
   endtask

   // send the collected bytes; an occasional early string end goes deeper
   task automatic flush_chunk(input logic fin_last);
      int i;
      logic fin;
      for (i = 0; i < chunk_q.size(); i++) begin
         if (i == chunk_q.size() - 1) fin = fin_last;
         else fin = ($urandom_range(99, 0) < 3);
         send_item(sgr_pkg::OpText, chunk_q[i], fin);
      end
      chunk_q.delete();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      if ($urandom_range(99, 0) < 70) return 8'($urandom_range(8'h7E, 8'h20));
      return 8'($urandom_range(255, 1));
   endfunction

   task automatic random_chunk();
      int pick;
      int nvals;
      int v;
      int i;
      logic fin;
      pick = $urandom_range(99, 0);
      fin  = ($urandom_range(3, 0) == 0);
      if (pick < 45) begin
         // mostly well-formed SGR with random values, sometimes one too many
         chunk_q.push_back(sgr_pkg::ChEsc);
         chunk_q.push_back(sgr_pkg::ChOpen);
         nvals = $urandom_range(4, 0);
         for (i = 0; i < nvals; i++) begin
            if (i > 0) chunk_q.push_back(sgr_pkg::ChSemi);
            case ($urandom_range(3, 0))
               0:       v = $urandom_range(1, 0);
               1, 2:    v = $urandom_range(37, 30);
               default: v = $urandom_range(999, 0);
            endcase
            add_str($sformatf("%0d", v));
         end
         if ($urandom_range(9, 0) != 0) chunk_q.push_back(sgr_pkg::ChM);
         else chunk_q.push_back(8'($urandom_range(255, 1)));
         repeat ($urandom_range(3, 1)) chunk_q.push_back(text_byte());
      end else if (pick < 80) begin
         repeat ($urandom_range(6, 1)) chunk_q.push_back(text_byte());
      end else if (pick < 88) begin
         chunk_q.push_back(sgr_pkg::ChEsc);
         chunk_q.push_back(8'($urandom_range(255, 0)));
      end else if (pick < 96) begin
         repeat ($urandom_range(3, 1)) chunk_q.push_back(8'($urandom_range(255, 0)));
      end else begin
         send_item(sgr_pkg::OpClear, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
         return;
      end
      flush_chunk(fin);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = sgr_pkg::OpText;
      req_char_in    = 8'h00;
      req_string_end = 1'b0;
      req_gap_pct    = 0;
      stall_pct      = 0;
      sent           = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      req_gap_pct = 30;
      stall_pct   = 30;
      add_str("A");
      flush_chunk(1'b0);
      chunk_q.push_back(sgr_pkg::ChEsc);
      add_str("[1;35m");
      flush_chunk(1'b0);
      chunk_q.push_back(8'hFF);
      flush_chunk(1'b1);
      chunk_q.push_back(sgr_pkg::ChEsc);
      add_str("q");
      flush_chunk(1'b0);
      chunk_q.push_back(sgr_pkg::ChEsc);
      flush_chunk(1'b1);
      // saturated value, then a full list closed by 'm'
      chunk_q.push_back(sgr_pkg::ChEsc);
      add_str("[999;;;m");
      flush_chunk(1'b0);
      chunk_q.push_back(sgr_pkg::ChEsc);
      add_str("[z");
      flush_chunk(1'b0);
      chunk_q.push_back(sgr_pkg::ChEsc);
      add_str("[3");
      flush_chunk(1'b1);
      chunk_q.push_back(sgr_pkg::ChNul);
      flush_chunk(1'b1);
      send_item(sgr_pkg::OpClear, 8'hA5, 1'b1);
      drain();

      sent = 0;
      while (sent < RandomItems) begin
         if (sent % 40 == 0) begin
            case ($urandom_range(2, 0))
               0: begin
                  req_gap_pct = 0;
                  stall_pct   = 0;
               end
               1: begin
                  req_gap_pct = 20;
                  stall_pct   = 20;
               end
               default: begin
                  req_gap_pct = $urandom_range(60, 0);
                  stall_pct   = $urandom_range(70, 10);
               end
            endcase
         end
         random_chunk();
         if ($urandom_range(99, 0) < 3) drain();
      end

      drain();
      repeat (16) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("ansi_sgr_color_text_parser regression: pass");
      end else begin
         $display("ansi_sgr_color_text_parser regression: fail");
      end
      $finish;
   end

endmodule
